// ----- rtl/batch_weigh_dose_mix_sequencer_unit_defines.svh -----
`ifndef BATCH_WEIGH_DOSE_MIX_SEQUENCER_UNIT_DEFINES_SVH
`define BATCH_WEIGH_DOSE_MIX_SEQUENCER_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define BWDS_ASSERT_NOW(label, ck, rst_n, trig, cond, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define BWDS_ASSERT_NEXT(label, ck, rst_n, trig, cond, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/bwds_pkg.sv -----
`default_nettype none

package bwds_pkg;

	localparam int NUM_INGREDIENTS_DEF = 3;
	localparam int NUM_TANKS_DEF       = 5;
	localparam int MAX_INGREDIENTS     = 3;
	localparam int IDX_BITS            = 2;
	localparam int TANK_BITS           = 5;
	localparam int TANK_ID_BITS        = 3;
	localparam int FIELD_BITS          = 16;
	localparam int WEIGHT_BITS         = 16;
	localparam int TICK_BITS           = 8;
	localparam int PHASE_BITS          = 3;
	localparam int KIND_BITS           = 2;
	localparam int QUEUE_DEPTH         = 2;
	localparam int ADDR_BITS           = 5;
	localparam int DATA_BITS           = 32;

	localparam logic [TICK_BITS-1:0] DISCHARGE_RST = 8'd100;
	localparam logic [TICK_BITS-1:0] MIX_END_RST   = 8'd200;

	localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_STOP  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd2;

	localparam logic [PHASE_BITS-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_CHECK = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_DOSE  = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_MIX   = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_DONE  = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_ABORT = 3'd5;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_START,
		OP_STOP,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic                       found;
		logic [WEIGHT_BITS-1:0]     scale;
		logic [MAX_INGREDIENTS-1:0] short_mask;
	} cmd_t;

	typedef struct packed {
		logic [MAX_INGREDIENTS-1:0][FIELD_BITS-1:0]   need;
		logic [MAX_INGREDIENTS-1:0][TANK_ID_BITS-1:0] tank;
		logic [TICK_BITS-1:0]                         discharge;
		logic [TICK_BITS-1:0]                         mix_end;
	} cfg_t;

	typedef struct packed {
		logic                 outlet;
		logic                 motor;
		logic                 scale;
		logic [TANK_BITS-1:0] tanks;
	} act_t;

endpackage

`default_nettype wire

// ----- rtl/bwds_if.sv -----
`default_nettype none

interface bwds_req_if;
	import bwds_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [KIND_BITS-1:0]  kind;
	logic                  order_found;
	logic [FIELD_BITS-1:0] scale_weight;
	logic [FIELD_BITS-1:0] level_0;
	logic [FIELD_BITS-1:0] level_1;
	logic [FIELD_BITS-1:0] level_2;

	modport source (
		output valid, kind, order_found, scale_weight, level_0, level_1, level_2,
		input ready
	);
	modport sink (
		input valid, kind, order_found, scale_weight, level_0, level_1, level_2,
		output ready
	);
endinterface

interface bwds_rsp_if;
	import bwds_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [TANK_BITS-1:0]       tank_valves;
	logic                       scale_valve_open;
	logic                       mixer_motor_on;
	logic                       mixer_outlet_open;
	logic [PHASE_BITS-1:0]      phase;
	logic [MAX_INGREDIENTS-1:0] shortage_mask;
	logic                       order_done;
	logic                       aborted;

	modport source (
		output valid, tank_valves, scale_valve_open, mixer_motor_on, mixer_outlet_open,
		phase, shortage_mask, order_done, aborted,
		input ready
	);
	modport sink (
		input valid, tank_valves, scale_valve_open, mixer_motor_on, mixer_outlet_open,
		phase, shortage_mask, order_done, aborted,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/batch_weigh_dose_mix_sequencer_unit.sv -----
`default_nettype none
// channel | dir | payload
// req     | in  | kind, order_found, scale_weight, level_0..level_2
// rsp     | out | tank_valves, scale_valve_open, mixer_motor_on, mixer_outlet_open,
//         |     | phase, shortage_mask, order_done, aborted
// apb     | in  | register writes and reads, 4 bytes per register
//
// one item per cycle sustained while rsp is ready; an item taken at req is first
// written into a queue slot, then popped from it into the output register
// a two entry queue parts the front from the sequencer, so req keeps flowing while
// rsp is stalled until the queue fills
// reset clears the sequencer to idle with all actuators closed, no clearing pass

module batch_weigh_dose_mix_sequencer_unit #(
	parameter int NUM_INGREDIENTS = bwds_pkg::NUM_INGREDIENTS_DEF,
	parameter int NUM_TANKS       = bwds_pkg::NUM_TANKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bwds_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bwds_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bwds_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	bwds_req_if.sink                           req,
	bwds_rsp_if.source                         rsp
);
	import bwds_pkg::*;

	cfg_t cfg;
	cmd_t wr_cmd;
	cmd_t rd_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;

	bwds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bwds_front #(
		.NUM_INGREDIENTS (NUM_INGREDIENTS)
	) u_front (
		.req  (req),
		.cfg  (cfg),
		.full (full),
		.push (push),
		.cmd  (wr_cmd)
	);

	bwds_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.empty  (empty)
	);

	bwds_back #(
		.NUM_INGREDIENTS (NUM_INGREDIENTS),
		.NUM_TANKS       (NUM_TANKS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (rd_cmd),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/bwds_cfg.sv -----
`default_nettype none

module bwds_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bwds_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [bwds_pkg::DATA_BITS-1:0] pwdata,
	output logic      [bwds_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output bwds_pkg::cfg_t                     cfg
);
	import bwds_pkg::*;

	localparam int REG_BITS = ADDR_BITS - 2;
	localparam logic [REG_BITS-1:0] REG_NEED_0    = 3'd0;
	localparam logic [REG_BITS-1:0] REG_NEED_1    = 3'd1;
	localparam logic [REG_BITS-1:0] REG_NEED_2    = 3'd2;
	localparam logic [REG_BITS-1:0] REG_TANK_0    = 3'd3;
	localparam logic [REG_BITS-1:0] REG_TANK_1    = 3'd4;
	localparam logic [REG_BITS-1:0] REG_TANK_2    = 3'd5;
	localparam logic [REG_BITS-1:0] REG_DISCHARGE = 3'd6;
	localparam logic [REG_BITS-1:0] REG_MIX_END   = 3'd7;

	cfg_t              cfg_q;
	logic [REG_BITS-1:0] reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.need      <= '0;
			cfg_q.tank[0]   <= TANK_ID_BITS'(0);
			cfg_q.tank[1]   <= TANK_ID_BITS'(1);
			cfg_q.tank[2]   <= TANK_ID_BITS'(2);
			cfg_q.discharge <= DISCHARGE_RST;
			cfg_q.mix_end   <= MIX_END_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_NEED_0:    cfg_q.need[0]   <= pwdata[FIELD_BITS-1:0];
				REG_NEED_1:    cfg_q.need[1]   <= pwdata[FIELD_BITS-1:0];
				REG_NEED_2:    cfg_q.need[2]   <= pwdata[FIELD_BITS-1:0];
				REG_TANK_0:    cfg_q.tank[0]   <= pwdata[TANK_ID_BITS-1:0];
				REG_TANK_1:    cfg_q.tank[1]   <= pwdata[TANK_ID_BITS-1:0];
				REG_TANK_2:    cfg_q.tank[2]   <= pwdata[TANK_ID_BITS-1:0];
				REG_DISCHARGE: cfg_q.discharge <= pwdata[TICK_BITS-1:0];
				REG_MIX_END:   cfg_q.mix_end   <= pwdata[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_NEED_0:    prdata = DATA_BITS'(cfg_q.need[0]);
			REG_NEED_1:    prdata = DATA_BITS'(cfg_q.need[1]);
			REG_NEED_2:    prdata = DATA_BITS'(cfg_q.need[2]);
			REG_TANK_0:    prdata = DATA_BITS'(cfg_q.tank[0]);
			REG_TANK_1:    prdata = DATA_BITS'(cfg_q.tank[1]);
			REG_TANK_2:    prdata = DATA_BITS'(cfg_q.tank[2]);
			REG_DISCHARGE: prdata = DATA_BITS'(cfg_q.discharge);
			REG_MIX_END:   prdata = DATA_BITS'(cfg_q.mix_end);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/bwds_front.sv -----
`default_nettype none

module bwds_front #(
	parameter int NUM_INGREDIENTS = bwds_pkg::NUM_INGREDIENTS_DEF
) (
	bwds_req_if.sink             req,
	input  wire bwds_pkg::cfg_t  cfg,
	input  wire logic            full,
	output logic                 push,
	output bwds_pkg::cmd_t       cmd
);
	import bwds_pkg::*;

	logic [MAX_INGREDIENTS-1:0][FIELD_BITS-1:0] level;

	assign level     = {req.level_2, req.level_1, req.level_0};
	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		cmd.found = req.order_found;
		cmd.scale = req.scale_weight[WEIGHT_BITS-1:0];
		case (req.kind)
			KIND_START: cmd.op = OP_START;
			KIND_STOP:  cmd.op = OP_STOP;
			KIND_TICK:  cmd.op = OP_TICK;
			default:    cmd.op = OP_NOP;
		endcase
		// level check done up front, only the mask travels on
		for (int i = 0; i < MAX_INGREDIENTS; i++) begin
			cmd.short_mask[i] = (i < NUM_INGREDIENTS) && (level[i] < cfg.need[i]);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bwds_fifo.sv -----
`default_nettype none
`include "batch_weigh_dose_mix_sequencer_unit_defines.svh"

module bwds_fifo #(
	parameter int DEPTH = bwds_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bwds_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           pop,
	output bwds_pkg::cmd_t      rd_cmd,
	output logic                empty
);
	import bwds_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

	cmd_t                slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BWDS_ASSERT_NOW(a_no_overrun, clk, arst_n, 1'b1, count_q <= CNT_FULL, "queue count beyond depth")
	`BWDS_ASSERT_NOW(a_no_underrun, clk, arst_n, pop, !empty, "pop from empty queue")
	`BWDS_ASSERT_NEXT(a_push_only, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ----- rtl/bwds_back.sv -----
`default_nettype none
`include "batch_weigh_dose_mix_sequencer_unit_defines.svh"

module bwds_back #(
	parameter int NUM_INGREDIENTS = bwds_pkg::NUM_INGREDIENTS_DEF,
	parameter int NUM_TANKS       = bwds_pkg::NUM_TANKS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bwds_pkg::cfg_t cfg,
	input  wire bwds_pkg::cmd_t cmd,
	input  wire logic           empty,
	output logic                pop,
	bwds_rsp_if.source          rsp
);
	import bwds_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_DOSE  = 6'b000100,
		ST_MIX   = 6'b001000,
		ST_DONE  = 6'b010000,
		ST_ABORT = 6'b100000
	} state_t;

	localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

	state_t                     st_q, st_d;
	logic [IDX_BITS-1:0]        idx_q, idx_d;
	logic [WEIGHT_BITS-1:0]     acc_q, acc_d;
	logic [TICK_BITS-1:0]       mix_q, mix_d;
	act_t                       act_q, act_d;
	logic [MAX_INGREDIENTS-1:0] short_q, short_d;
	logic                       done_p, abort_p;

	logic [FIELD_BITS-1:0]      need_sel;
	logic [TANK_ID_BITS-1:0]    tank_sel;
	logic [WEIGHT_BITS:0]       target;
	logic [TANK_BITS-1:0]       vbit;
	logic [IDX_BITS:0]          idx_next;

	logic                       out_valid_q;

	function automatic logic [TANK_BITS-1:0] valve_of(input logic [TANK_ID_BITS-1:0] t);
		logic [TANK_BITS-1:0] v;
		v = '0;
		for (int k = 0; k < TANK_BITS; k++) begin
			v[k] = (t == TANK_ID_BITS'(k)) && (k < NUM_TANKS);
		end
		return v;
	endfunction

	function automatic logic [PHASE_BITS-1:0] phase_of(input state_t s);
		logic [PHASE_BITS-1:0] p;
		case (s)
			ST_IDLE:  p = PH_IDLE;
			ST_CHECK: p = PH_CHECK;
			ST_DOSE:  p = PH_DOSE;
			ST_MIX:   p = PH_MIX;
			ST_DONE:  p = PH_DONE;
			ST_ABORT: p = PH_ABORT;
			default:  p = PH_IDLE;
		endcase
		return p;
	endfunction

	assign pop = !empty && (!out_valid_q || rsp.ready);

	always_comb begin
		case (idx_q)
			2'd1:    begin need_sel = cfg.need[1]; tank_sel = cfg.tank[1]; end
			2'd2:    begin need_sel = cfg.need[2]; tank_sel = cfg.tank[2]; end
			default: begin need_sel = cfg.need[0]; tank_sel = cfg.tank[0]; end
		endcase
	end

	// target kept one bit wider so a large need never wraps
	assign target   = {1'b0, need_sel[WEIGHT_BITS-1:0]} + {1'b0, acc_q};
	assign vbit     = valve_of(tank_sel);
	assign idx_next = {1'b0, idx_q} + 1'b1;

	always_comb begin
		st_d    = st_q;
		idx_d   = idx_q;
		acc_d   = acc_q;
		mix_d   = mix_q;
		act_d   = act_q;
		short_d = short_q;
		done_p  = 1'b0;
		abort_p = 1'b0;
		case (cmd.op)
			OP_START: begin
				idx_d   = '0;
				acc_d   = '0;
				mix_d   = '0;
				act_d   = '0;
				short_d = '0;
				if (cmd.found) begin
					st_d = ST_CHECK;
				end else begin
					st_d    = ST_ABORT;
					abort_p = 1'b1;
				end
			end
			OP_STOP: begin
				act_d   = '0;
				st_d    = ST_ABORT;
				abort_p = 1'b1;
			end
			OP_TICK: begin
				case (st_q)
					ST_CHECK: begin
						if (cmd.short_mask != '0) begin
							short_d = cmd.short_mask;
							act_d   = '0;
							st_d    = ST_ABORT;
							abort_p = 1'b1;
						end else begin
							st_d  = ST_DOSE;
							idx_d = '0;
							acc_d = '0;
						end
					end
					ST_DOSE: begin
						if ({1'b0, cmd.scale} < target) begin
							act_d.tanks = act_q.tanks | vbit;
						end else begin
							act_d.tanks = act_q.tanks & ~vbit;
							acc_d       = cmd.scale;
							idx_d       = idx_next[IDX_BITS-1:0];
							if (idx_next >= (IDX_BITS+1)'(NUM_INGREDIENTS)) begin
								idx_d = '0;
								st_d  = ST_MIX;
								mix_d = '0;
							end
						end
					end
					ST_MIX: begin
						// discharge first, then motor until the end tick
						if (mix_q < cfg.discharge) begin
							act_d.scale = 1'b1;
						end else begin
							act_d.scale = 1'b0;
							act_d.motor = 1'b1;
							if (mix_q == cfg.mix_end) begin
								act_d.motor  = 1'b0;
								act_d.outlet = 1'b1;
								mix_d        = '0;
								st_d         = ST_DONE;
								done_p       = 1'b1;
							end
						end
						if (mix_d < TICK_MAX) begin
							mix_d = mix_d + 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			idx_q   <= '0;
			acc_q   <= '0;
			mix_q   <= '0;
			act_q   <= '0;
			short_q <= '0;
		end else if (pop) begin
			st_q    <= st_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			mix_q   <= mix_d;
			act_q   <= act_d;
			short_q <= short_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp.tank_valves       <= act_d.tanks;
			rsp.scale_valve_open  <= act_d.scale;
			rsp.mixer_motor_on    <= act_d.motor;
			rsp.mixer_outlet_open <= act_d.outlet;
			rsp.phase             <= phase_of(st_d);
			rsp.shortage_mask     <= short_d;
			rsp.order_done        <= done_p;
			rsp.aborted           <= abort_p;
		end
	end

	assign rsp.valid = out_valid_q;

	`BWDS_ASSERT_NOW(a_pulse_excl, clk, arst_n, rsp.valid, !(rsp.order_done && rsp.aborted), "done and abort on one item")
	`BWDS_ASSERT_NOW(a_motor_excl, clk, arst_n, rsp.valid && rsp.mixer_motor_on, !rsp.scale_valve_open && !rsp.mixer_outlet_open, "motor runs with a mixer valve open")
	`BWDS_ASSERT_NEXT(a_done_item, clk, arst_n, pop && done_p, rsp.valid && rsp.phase == PH_DONE && rsp.mixer_outlet_open, "done item not shown as done")

endmodule

`default_nettype wire
